// ----- design/tga_rle_pixel_decoder_macros.svh -----
// Assertion macros for the TGA run-length pixel decoder.
// Included by the files that check their own logic; define ASSERT_OFF to drop them.
`ifndef TGA_RLE_PIXEL_DECODER_MACROS_SVH
`define TGA_RLE_PIXEL_DECODER_MACROS_SVH
`ifndef ASSERT_OFF
// ante implies cons in the same cycle
`define TRD_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// ante implies cons in the next cycle
`define TRD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TRD_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define TRD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ----- design/trd_pkg.sv -----
// Shared types and constants of the TGA run-length pixel decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package trd_pkg;

  localparam int unsigned CFG_ADDR_W = 2;

  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_BPP   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_TOTAL = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_RLE   = 2'd2;

  localparam logic [2:0]  BPP_RESET   = 3'd4;
  localparam logic [31:0] TOTAL_RESET = 32'd0;
  localparam logic        RLE_RESET   = 1'b1;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_TOO_MANY  = 2'd1,
    ERR_EARLY_END = 2'd2
  } err_e;

  typedef struct packed {
    logic [2:0]  bytes_per_pixel;
    logic [31:0] pixel_total;
    logic        rle_enable;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic        emit;
    logic [31:0] pixel_value;
    logic [7:0]  run_length;
    logic        image_done;
    err_e        error_code;
  } result_t;

endpackage

// ----- design/trd_in_stage.sv -----
// Input register of the TGA run-length pixel decoder.
// Depends on trd_pkg for the input transaction type.
`timescale 1ns / 1ps

module trd_in_stage import trd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  in_item_t item_i,
  input  logic     take_i,
  output logic     valid_o,
  output in_item_t item_o
);

  logic     valid_q;
  logic     valid_d;
  in_item_t item_q;

  // Refill in the same cycle the held byte is consumed.
  assign ready_o = !valid_q || take_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- design/trd_decode.sv -----
// Decoder state and per-byte step logic: packet headers, pixel assembly, counting.
// Depends on trd_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "tga_rle_pixel_decoder_macros.svh"

module trd_decode import trd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     take_i,
  input  in_item_t item_i,
  input  cfg_t     cfg_i,
  output result_t  res_o
);

  typedef enum logic {
    PH_HEADER,
    PH_PIXEL
  } phase_e;

  phase_e      phase_q, phase_d;
  logic        run_q, run_d;
  logic [7:0]  left_q, left_d;
  logic [1:0]  idx_q, idx_d;
  logic [31:0] asm_q, asm_d;
  logic [31:0] done_q, done_d;
  logic        stopped_q, stopped_d;

  logic [1:0]  bpp_m1;
  logic [32:0] diff;
  logic [31:0] rem;
  logic        rem_zero;
  logic        rem_small;
  logic [7:0]  hdr_len;
  logic        hdr_too_long;
  logic [7:0]  n;
  logic        n_gt_rem;
  logic        n_eq_rem;
  logic        at_boundary;
  logic [31:0] asm_new;

  always_comb begin
    case (cfg_i.bytes_per_pixel)
      3'd0, 3'd1: bpp_m1 = 2'd0;
      3'd2:       bpp_m1 = 2'd1;
      3'd3:       bpp_m1 = 2'd2;
      default:    bpp_m1 = 2'd3;
    endcase
  end

  // Pixels still missing, floored at zero.
  assign diff      = {1'b0, cfg_i.pixel_total} - {1'b0, done_q};
  assign rem       = diff[32] ? 32'd0 : diff[31:0];
  assign rem_zero  = (rem == 32'd0);
  assign rem_small = (rem[31:8] == 24'd0);

  assign hdr_len      = {1'b0, item_i.data_byte[6:0]} + 8'd1;
  assign hdr_too_long = rem_small && (hdr_len > rem[7:0]);

  assign n        = (cfg_i.rle_enable && run_q && (left_q != 8'd0)) ? left_q : 8'd1;
  assign n_gt_rem = rem_small && (n > rem[7:0]);
  assign n_eq_rem = rem_small && (n == rem[7:0]);

  assign at_boundary = (idx_q == 2'd0) && (!cfg_i.rle_enable || (phase_q == PH_HEADER));

  assign asm_new = ((idx_q == 2'd0) ? 32'd0 : asm_q)
                 | ({24'd0, item_i.data_byte} << {idx_q, 3'b000});

  always_comb begin
    phase_d   = phase_q;
    run_d     = run_q;
    left_d    = left_q;
    idx_d     = idx_q;
    asm_d     = asm_q;
    done_d    = done_q;
    stopped_d = stopped_q;
    res_o     = '0;

    if (!stopped_q) begin
      if (item_i.end_of_stream) begin
        stopped_d = 1'b1;
        if (!(at_boundary && rem_zero)) begin
          res_o.emit       = 1'b1;
          res_o.error_code = ERR_EARLY_END;
        end
      end else if (cfg_i.rle_enable && (phase_q == PH_HEADER)) begin
        if (hdr_too_long) begin
          stopped_d        = 1'b1;
          res_o.emit       = 1'b1;
          res_o.error_code = ERR_TOO_MANY;
        end else begin
          run_d   = item_i.data_byte[7];
          left_d  = hdr_len;
          phase_d = PH_PIXEL;
          idx_d   = 2'd0;
          asm_d   = 32'd0;
        end
      end else if ((idx_q == 2'd0) && !cfg_i.rle_enable && rem_zero) begin
        stopped_d        = 1'b1;
        res_o.emit       = 1'b1;
        res_o.error_code = ERR_TOO_MANY;
      end else begin
        asm_d = asm_new;
        if (idx_q < bpp_m1) begin
          idx_d = idx_q + 2'd1;
        end else begin
          idx_d = 2'd0;
          if (n_gt_rem) begin
            stopped_d        = 1'b1;
            res_o.emit       = 1'b1;
            res_o.error_code = ERR_TOO_MANY;
          end else begin
            done_d = done_q + {24'd0, n};
            if (cfg_i.rle_enable) begin
              if (run_q || (left_q <= 8'd1)) begin
                left_d  = 8'd0;
                phase_d = PH_HEADER;
              end else begin
                left_d = left_q - 8'd1;
              end
            end
            stopped_d         = n_eq_rem;
            res_o.emit        = 1'b1;
            res_o.pixel_value = asm_new;
            res_o.run_length  = n;
            res_o.image_done  = n_eq_rem;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      run_q     <= 1'b0;
      left_q    <= 8'd0;
      idx_q     <= 2'd0;
      asm_q     <= 32'd0;
      done_q    <= 32'd0;
      stopped_q <= 1'b0;
    end else if (take_i) begin
      phase_q   <= phase_d;
      run_q     <= run_d;
      left_q    <= left_d;
      idx_q     <= idx_d;
      asm_q     <= asm_d;
      done_q    <= done_d;
      stopped_q <= stopped_d;
    end
  end

  `TRD_ASSERT_IMPL(a_stopped_silent, clk_i, rst_ni, stopped_q, !res_o.emit, "result while stopped")
  `TRD_ASSERT_NEXT(a_final_stops, clk_i, rst_ni, take_i && res_o.emit && (res_o.image_done || (res_o.error_code != ERR_NONE)), stopped_q, "no stop after final result")
  `TRD_ASSERT_IMPL(a_pixel_phase_left, clk_i, rst_ni, phase_q == PH_PIXEL, left_q != 8'd0, "pixel phase with empty packet")

endmodule

// ----- design/tga_rle_pixel_decoder.sv -----
// TGA run-length pixel decoder: one image data byte in per cycle unless the result side
// stalls, one run or pixel out. An accepted byte lands in an input register that feeds the
// per-byte step logic, whose result lands in an output register. A new byte is taken every
// cycle while no stall holds it; the throughput is set by the update of the decoder state
// (pixel count, packet count, byte index), which each byte depends on. A stall on the
// result side while a result waits holds the byte in the input register and drops
// s_axis_tready_o in the same cycle. In run-length mode a packet header byte yields no
// result; each run is reported once with its length instead of expanded.
// Results flag the last pixel of the image (tlast) and errors (tuser); after either, or a
// silent end of stream at a pixel boundary, the block accepts bytes but gives no results
// until reset. Configuration writes take effect at once and must come while idle.
// Depends on trd_pkg, trd_in_stage, trd_decode and the assertion macros header.
`timescale 1ns / 1ps
`include "tga_rle_pixel_decoder_macros.svh"

module tga_rle_pixel_decoder import trd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [31:0]           cfg_data_i,
  // byte stream in
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [7:0]            s_axis_tdata_i,  // [7:0] data_byte
  input  logic                  s_axis_tuser_i,  // [0] end_of_stream
  // results out
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [39:0]           m_axis_tdata_o,  // [31:0] pixel_value, [39:32] run_length
  output logic                  m_axis_tlast_o,  // image_done
  output logic [1:0]            m_axis_tuser_o   // [1:0] error_code
);

  cfg_t     cfg_q;
  in_item_t in_item;
  in_item_t held_item;
  logic     held_valid;
  logic     take;
  result_t  res;
  result_t  res_q;
  logic     out_valid_q, out_valid_d;

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bytes_per_pixel <= BPP_RESET;
      cfg_q.pixel_total     <= TOTAL_RESET;
      cfg_q.rle_enable      <= RLE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_IDX_BPP:   cfg_q.bytes_per_pixel <= cfg_data_i[2:0];
        CFG_IDX_TOTAL: cfg_q.pixel_total     <= cfg_data_i;
        CFG_IDX_RLE:   cfg_q.rle_enable      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign in_item.data_byte     = s_axis_tdata_i;
  assign in_item.end_of_stream = s_axis_tuser_i;

  trd_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .item_i  (in_item),
    .take_i  (take),
    .valid_o (held_valid),
    .item_o  (held_item)
  );

  // The held byte is processed when the output register is free or draining.
  assign take = held_valid && (!out_valid_q || m_axis_tready_i);

  trd_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .item_i (held_item),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = res.emit;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && res.emit) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {res_q.run_length, res_q.pixel_value};
  assign m_axis_tlast_o  = res_q.image_done;
  assign m_axis_tuser_o  = res_q.error_code;

  `TRD_ASSERT_IMPL(a_err_fields_zero, clk_i, rst_ni, out_valid_q && (res_q.error_code != ERR_NONE), (res_q.pixel_value == 32'd0) && (res_q.run_length == 8'd0) && !res_q.image_done, "error result with payload")
  `TRD_ASSERT_IMPL(a_run_nonzero, clk_i, rst_ni, out_valid_q && (res_q.error_code == ERR_NONE), res_q.run_length != 8'd0, "pixel result with zero run")
  `TRD_ASSERT_NEXT(a_take_loads, clk_i, rst_ni, take && res.emit, out_valid_q, "emitted result not held")

endmodule

// ----- bench/tb.sv -----
// Self-checking testbench for tga_rle_pixel_decoder: directed and random byte streams in
// both run-length and raw modes, checked against a cycle-free model of the decoder state.
// Depends on trd_pkg and the decoder RTL only.
`timescale 1ns / 1ps

module tb import trd_pkg::*; ();

  // Index 3 decodes to no register; writes to it must be dropped.
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_SPARE = 2'd3;
  // Largest image the format allows (65535 x 65535).
  localparam logic [31:0] TOTAL_HIGH = 32'd4294836225;

  typedef enum logic {
    PH_HEADER,
    PH_PIXEL
  } pkt_phase_e;

  // Ways the one and only image of the run is brought to an end.
  typedef enum int unsigned {
    END_COMPLETE,
    END_LONG_HEADER,
    END_RAW_OVERFLOW,
    END_ZERO_TOTAL,
    END_TRUNCATED,
    END_EOS
  } end_kind_e;

  // Tracks decoder state per accepted byte and holds the runs it must emit, in order.
  class tga_run_scoreboard;
    logic [2:0]  bpp_cfg;
    logic [31:0] total_cfg;
    logic        rle_cfg;
    pkt_phase_e  phase;
    logic        run_pkt;
    logic [7:0]  left_in_pkt;
    logic [1:0]  byte_idx;
    logic [31:0] assembly;
    logic [31:0] done_cnt;
    logic        halted;
    result_t     expected_runs[$];
    int unsigned mismatch_cnt;

    function new();
      bpp_cfg      = BPP_RESET;
      total_cfg    = TOTAL_RESET;
      rle_cfg      = RLE_RESET;
      phase        = PH_HEADER;
      run_pkt      = 1'b0;
      left_in_pkt  = '0;
      byte_idx     = '0;
      assembly     = '0;
      done_cnt     = '0;
      halted       = 1'b0;
      mismatch_cnt = 0;
    endfunction

    function void note_config(logic [CFG_ADDR_W-1:0] idx, logic [31:0] val);
      case (idx)
        CFG_IDX_BPP:   bpp_cfg = val[2:0];
        CFG_IDX_TOTAL: total_cfg = val;
        CFG_IDX_RLE:   rle_cfg = val[0];
        default: ;
      endcase
    endfunction

    function logic [31:0] missing();
      return (total_cfg > done_cnt) ? total_cfg - done_cnt : '0;
    endfunction

    // Out-of-range sizes clamp: 0 acts as 1, 5..7 as 4.
    function int unsigned eff_bpp();
      if (bpp_cfg == 0) return 1;
      if (bpp_cfg > 4) return 4;
      return int'(bpp_cfg);
    endfunction

    function logic at_boundary();
      return byte_idx == 0 && (!rle_cfg || phase == PH_HEADER);
    endfunction

    function int unsigned pending();
      return expected_runs.size();
    endfunction

    function void queue_run(logic [31:0] value, logic [7:0] len, logic last, err_e err);
      result_t r;
      r.emit        = 1'b1;
      r.pixel_value = value;
      r.run_length  = len;
      r.image_done  = last;
      r.error_code  = err;
      expected_runs.push_back(r);
    endfunction

    // Errors zero the payload and freeze the decoder for good.
    function void queue_error(err_e err);
      halted = 1'b1;
      queue_run('0, '0, 1'b0, err);
    endfunction

    function void take_byte(logic [7:0] b, logic eos);
      logic [31:0] rem;
      logic [7:0]  len;
      logic [7:0]  n;
      rem = missing();
      if (halted) return;
      if (eos) begin
        // Clean end only at a pixel/packet boundary with the image complete.
        if (at_boundary() && rem == 0) halted = 1'b1;
        else queue_error(ERR_EARLY_END);
        return;
      end
      if (rle_cfg && phase == PH_HEADER) begin
        len = {1'b0, b[6:0]} + 8'd1;
        if (32'(len) > rem) begin
          queue_error(ERR_TOO_MANY);
          return;
        end
        run_pkt     = b[7];
        left_in_pkt = len;
        phase       = PH_PIXEL;
        byte_idx    = '0;
        assembly    = '0;
        return;
      end
      if (byte_idx == 0) begin
        if (!rle_cfg && rem == 0) begin
          queue_error(ERR_TOO_MANY);
          return;
        end
        assembly = '0;
      end
      assembly |= 32'(b) << (8 * byte_idx);
      if (int'(byte_idx) + 1 < eff_bpp()) begin
        byte_idx++;
        return;
      end
      byte_idx = '0;
      n = 8'd1;
      if (rle_cfg && run_pkt && left_in_pkt != 0) n = left_in_pkt;
      if (32'(n) > rem) begin
        queue_error(ERR_TOO_MANY);
        return;
      end
      done_cnt += 32'(n);
      if (rle_cfg) begin
        if (run_pkt || left_in_pkt <= 1) left_in_pkt = '0;
        else left_in_pkt--;
        if (left_in_pkt == 0) phase = PH_HEADER;
      end
      if (done_cnt >= total_cfg) begin
        halted = 1'b1;
        queue_run(assembly, n, 1'b1, ERR_NONE);
      end else begin
        queue_run(assembly, n, 1'b0, ERR_NONE);
      end
    endfunction

    function void report_mismatch(string msg);
      mismatch_cnt++;
      if (mismatch_cnt <= 10) $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    function void check_run(logic [31:0] value, logic [7:0] len, logic last, logic [1:0] err);
      result_t want;
      if (expected_runs.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%h len=%0d last=%b err=%0d",
                                  value, len, last, err));
        return;
      end
      want = expected_runs.pop_front();
      if (value !== want.pixel_value || len !== want.run_length ||
          last !== want.image_done || err !== want.error_code)
        report_mismatch($sformatf(
          "expected value=%h len=%0d last=%b err=%0d, got value=%h len=%0d last=%b err=%0d",
          want.pixel_value, want.run_length, want.image_done, want.error_code,
          value, len, last, err));
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [31:0]           cfg_data = '0;
  logic                  s_valid = 1'b0;
  logic [7:0]            s_data = '0;
  logic                  s_user = 1'b0;
  logic                  m_ready = 1'b1;
  logic                  s_axis_tready_o;
  logic                  m_axis_tvalid_o;
  logic [39:0]           m_axis_tdata_o;
  logic                  m_axis_tlast_o;
  logic [1:0]            m_axis_tuser_o;

  tga_run_scoreboard sb = new();
  // Random idling on both sides; cleared for the closing part of the run.
  logic              gaps_on = 1'b1;
  int unsigned       item_cnt = 0;

  tga_rle_pixel_decoder u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),   // [7:0] data_byte
    .s_axis_tuser_i  (s_user),   // [0] end_of_stream
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),  // [31:0] pixel_value, [39:32] run_length
    .m_axis_tlast_o  (m_axis_tlast_o),  // image_done
    .m_axis_tuser_o  (m_axis_tuser_o)   // [1:0] error_code
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Leaves cfg_we high; the caller lowers it once the batch of writes is done.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] val);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    sb.note_config(idx, val);
  endtask

  // One byte transaction; prediction runs at the edge where it is taken.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    s_user  <= eos;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (!sb.halted) item_cnt++;
    sb.take_byte(b, eos);
  endtask

  // Well-formed packet (or one raw pixel) with random content, never over cap pixels.
  task automatic send_packet(input int unsigned cap);
    int unsigned cnt;
    int unsigned bpp;
    logic        is_run;
    bpp = sb.eff_bpp();
    if (!sb.rle_cfg) begin
      repeat (bpp) send_byte(8'($urandom), 1'b0);
      return;
    end
    cnt    = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 6);
    is_run = 1'($urandom_range(0, 1));
    // long literal packets are costly; keep most of them short
    if (!is_run && cnt > 16 && $urandom_range(0, 3) != 0) cnt = cnt % 16 + 1;
    if (cnt > cap) cnt = cap;
    send_byte({is_run, 7'(cnt - 1)}, 1'b0);
    repeat (is_run ? 1 : cnt) repeat (bpp) send_byte(8'($urandom), 1'b0);
  endtask

  // Sender holds off until every expected result is out, then keeps waiting while a header
  // or partial pixel may still sit inside the two-stage pipe.
  task automatic drain();
    s_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Result side: check accepted transactions, stall in random bursts.
  initial begin
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_ready)
        sb.check_run(m_axis_tdata_o[31:0], m_axis_tdata_o[39:32], m_axis_tlast_o,
                     m_axis_tuser_o);
      if (hold != 0) begin
        hold--;
        if (hold == 0) m_ready <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 11) == 0) begin
        hold = $urandom_range(1, 10);
        m_ready <= 1'b0;
      end
    end
  end

  initial begin
    end_kind_e   ending;
    int unsigned npk;
    logic [31:0] v;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: 1-byte pixels; longest run, shortest literal, shortest run.
    // The image is made effectively endless so nothing stops the decoder early.
    write_reg(CFG_IDX_TOTAL, 32'hFFFF_FFFF);
    write_reg(CFG_IDX_BPP, {29'($urandom), 3'd1});
    write_reg(CFG_IDX_SPARE, $urandom);
    cfg_we <= 1'b0;
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h5A, 1'b0);
    drain();

    // 4-byte pixels: byte order within the word, all-ones pixel
    write_reg(CFG_IDX_BPP, 32'd4);
    cfg_we <= 1'b0;
    send_byte(8'h01, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h04, 1'b0);
    repeat (4) send_byte(8'hFF, 1'b0);
    drain();

    // size 0 behaves as one byte
    write_reg(CFG_IDX_BPP, 32'd0);
    cfg_we <= 1'b0;
    send_byte(8'h83, 1'b0);
    send_byte(8'hA5, 1'b0);
    drain();

    // size 7 behaves as four bytes; largest legal image size
    write_reg(CFG_IDX_BPP, 32'd7);
    write_reg(CFG_IDX_TOTAL, TOTAL_HIGH);
    cfg_we <= 1'b0;
    send_byte(8'h85, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);
    send_byte(8'h78, 1'b0);
    drain();

    // raw mode, 2-byte pixels; upper data bits must be ignored
    write_reg(CFG_IDX_RLE, {31'($urandom), 1'b0});
    write_reg(CFG_IDX_BPP, 32'd2);
    cfg_we <= 1'b0;
    send_byte(8'hC3, 1'b0);
    send_byte(8'h3C, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);

    // Random phases. Each starts from a drained block with fresh settings; some end in a
    // few stray bytes, leaving the next phase mid-packet or mid-pixel.
    while (item_cnt < 720) begin
      drain();
      gaps_on = (item_cnt < 640) && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1) == 0) write_reg(CFG_IDX_BPP, {29'($urandom), 3'($urandom)});
      if ($urandom_range(0, 2) == 0) write_reg(CFG_IDX_RLE, $urandom);
      if ($urandom_range(0, 5) == 0) begin
        if ($urandom_range(0, 2) == 0) v = 32'hFFFF_FFFF;
        else if ($urandom_range(0, 1) == 0) v = TOTAL_HIGH;
        else v = sb.done_cnt + $urandom_range(200000, 32'h3FFF_FFFF);
        write_reg(CFG_IDX_TOTAL, v);
      end
      if ($urandom_range(0, 7) == 0) write_reg(CFG_IDX_SPARE, $urandom);
      cfg_we <= 1'b0;
      npk = $urandom_range(3, 25);
      repeat (npk) send_packet(sb.missing());
      if ($urandom_range(0, 5) == 0)
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
    end

    // Closing part, no idling: get back to a boundary, then end the image one way.
    gaps_on = 1'b0;
    while (!sb.at_boundary()) send_byte(8'($urandom), 1'b0);
    drain();
    ending = end_kind_e'($urandom_range(0, 5));
    case (ending)
      END_COMPLETE: begin
        write_reg(CFG_IDX_TOTAL, sb.done_cnt + $urandom_range(1, 40));
        write_reg(CFG_IDX_RLE, $urandom);
        cfg_we <= 1'b0;
        while (!sb.halted) send_packet(sb.missing());
      end
      END_LONG_HEADER: begin
        // header count exceeds the pixels still missing
        write_reg(CFG_IDX_TOTAL, sb.done_cnt + $urandom_range(0, 3));
        write_reg(CFG_IDX_RLE, 32'd1);
        cfg_we <= 1'b0;
        send_byte({1'($urandom), 7'(sb.missing() + $urandom_range(0, 127 - sb.missing()))},
                  1'b0);
      end
      END_RAW_OVERFLOW: begin
        write_reg(CFG_IDX_TOTAL, sb.done_cnt);
        write_reg(CFG_IDX_RLE, 32'd0);
        cfg_we <= 1'b0;
        send_byte(8'($urandom), 1'b0);
      end
      END_ZERO_TOTAL: begin
        write_reg(CFG_IDX_TOTAL, 32'd0);
        write_reg(CFG_IDX_RLE, $urandom);
        cfg_we <= 1'b0;
        send_byte(8'($urandom), 1'b0);
      end
      END_TRUNCATED: begin
        // stream ends early, during or after a short literal packet
        write_reg(CFG_IDX_TOTAL, sb.done_cnt + 50);
        write_reg(CFG_IDX_RLE, 32'd1);
        cfg_we <= 1'b0;
        send_byte(8'h02, 1'b0);
        repeat ($urandom_range(0, 5)) send_byte(8'($urandom), 1'b0);
        send_byte(8'($urandom), 1'b1);
      end
      default: begin
        // end of stream at a boundary: silent if complete, early-end error otherwise
        if ($urandom_range(0, 2) == 0) v = 32'd0;
        else if ($urandom_range(0, 1) == 0) v = sb.done_cnt;
        else v = sb.done_cnt + 5;
        write_reg(CFG_IDX_TOTAL, v);
        cfg_we <= 1'b0;
        send_byte(8'($urandom), 1'b1);
      end
    endcase

    // the decoder is stopped now; whatever follows must produce nothing
    repeat (12) send_byte(8'($urandom), 1'($urandom));
    drain();
    repeat (20) @(posedge clk_i);
    if (sb.mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Hang guard, far above the slowest correct run.
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/trd_pkg.sv
design/trd_in_stage.sv
design/trd_decode.sv
design/tga_rle_pixel_decoder.sv
bench/tb.sv
